[hdl/mlcd_pkg.sv]
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared types and constants for the memory-LCD frame controller.
// ----------------------------------------------------------------------------
package mlcd_pkg;

   localparam int DEF_PANEL_WIDTH  = 96;
   localparam int DEF_PANEL_HEIGHT = 96;

   localparam int MODE_W = 2;
   localparam int POS_W  = 10;
   localparam int BYTE_W = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE   = 2'd0,
      MODE_READ    = 2'd1,
      MODE_CLEAR   = 2'd2,
      MODE_REFRESH = 2'd3
   } mode_type;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_SERIAL = 1'b1;

   localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_VCOM  = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h04;
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hff;
   localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] PIX_MSB   = 8'h80;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_MOD,
      ST_CLR_CMD,
      ST_CLR_END,
      ST_CLR_FILL,
      ST_REF_CMD,
      ST_REF_SCAN,
      ST_REF_ADDR,
      ST_REF_RD,
      ST_REF_DATA,
      ST_REF_TRAIL,
      ST_REF_END
   } state_type;

endpackage

[hdl/mlcd_req_if.sv]
// ----------------------------------------------------------------------------
// mlcd_req_if
// Request channel: pixel write/read, clear and refresh-step commands.
// ----------------------------------------------------------------------------
interface mlcd_req_if;
   logic                         valid;
   logic                         ready;
   logic [mlcd_pkg::MODE_W-1:0]  mode;
   logic [mlcd_pkg::POS_W-1:0]   x_pos;
   logic [mlcd_pkg::POS_W-1:0]   y_pos;
   logic                         pixel_on;

   modport source (output valid, output mode, output x_pos, output y_pos,
                   output pixel_on, input ready);
   modport sink   (input valid, input mode, input x_pos, input y_pos,
                   input pixel_on, output ready);
endinterface

[hdl/mlcd_rsp_if.sv]
// ----------------------------------------------------------------------------
// mlcd_rsp_if
// Response channel: pixel read answers and serial bytes for the panel link.
// ----------------------------------------------------------------------------
interface mlcd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic                         pixel_value;
   logic [mlcd_pkg::BYTE_W-1:0]  serial_byte;
   logic                         frame_last;

   modport source (output valid, output kind, output pixel_value,
                   output serial_byte, output frame_last, input ready);
   modport sink   (input valid, input kind, input pixel_value,
                   input serial_byte, input frame_last, output ready);
endinterface

[hdl/memory_lcd_frame_controller_unit.sv]
// ----------------------------------------------------------------------------
// memory_lcd_frame_controller_unit
// Memory-LCD controller: bit-packed frame store RAM, per-row dirty flags,
// serial byte stream for clear and refresh frames.
// ----------------------------------------------------------------------------
// Pixel write: accept, RAM read, write-back. Pixel read: answer loaded after
// the RAM read, once the response register is free. Clear: two bytes, then a
// fill sweep over every RAM byte before the next accept. Refresh step: one
// clean row scanned per cycle, a RAM read state then a data state per data byte
// (one RAM port, registered read), plus command/address/trailer/end bytes. One item at a time.
// Sync reset: dirty flags clear, VCOM one, no frame open; RAM undefined.
// ----------------------------------------------------------------------------
module memory_lcd_frame_controller_unit #(
   parameter int PANEL_WIDTH  = mlcd_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = mlcd_pkg::DEF_PANEL_HEIGHT
) (
   input  logic          clock,
   input  logic          reset,
   mlcd_req_if.sink      req,
   mlcd_rsp_if.source    rsp,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data
);

   localparam int ROW_BYTES   = PANEL_WIDTH / 8;
   localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int RW          = $clog2(PANEL_HEIGHT);
   localparam int CUW         = $clog2(PANEL_HEIGHT + 1);
   localparam int CW          = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   // frame store RAM
   logic [mlcd_pkg::BYTE_W-1:0] frame_store_mem [STORE_BYTES];
   logic [mlcd_pkg::BYTE_W-1:0] store_rdata_ff;
   logic                        mem_we;
   logic                        mem_re;
   logic [AW-1:0]               mem_addr;
   logic [mlcd_pkg::BYTE_W-1:0] mem_wdata;

   mlcd_pkg::state_type state_ff, state_in;

   logic                        rsp_valid_ff;
   logic                        rsp_kind_ff;
   logic                        rsp_pix_ff;
   logic [mlcd_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                        rsp_last_ff;

   logic                        out_load;
   logic                        out_kind;
   logic                        out_pix;
   logic [mlcd_pkg::BYTE_W-1:0] out_byte;
   logic                        out_last;

   logic [PANEL_HEIGHT-1:0]     dirty_ff, dirty_in;
   logic                        vcom_ff, vcom_in;
   logic                        busy_ff, busy_in;
   logic [CUW-1:0]              cursor_ff, cursor_in;
   logic                        offset_ff;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [CW-1:0]               cnt_ff, cnt_in;

   mlcd_pkg::mode_type          mode_ff;
   logic                        pix_on_ff;
   logic                        in_range_ff;
   logic [mlcd_pkg::BYTE_W-1:0] mask_ff;
   logic [RW-1:0]               yrow_ff;

   logic                        req_fire;
   logic                        can_load;
   logic                        scan_end;
   logic                        row_last_byte;
   logic [mlcd_pkg::BYTE_W-1:0] vcom_bit;
   logic [mlcd_pkg::BYTE_W-1:0] row_addr_byte;
   logic                        req_in_range;

   assign req.ready     = (state_ff == mlcd_pkg::ST_IDLE);
   assign req_fire      = req.valid && req.ready;
   assign can_load      = !rsp_valid_ff || rsp.ready;
   assign scan_end      = (cursor_ff == CUW'(PANEL_HEIGHT));
   assign row_last_byte = (cnt_ff == CW'(ROW_BYTES - 1));
   assign vcom_bit      = vcom_ff ? mlcd_pkg::CMD_VCOM : mlcd_pkg::ZERO_BYTE;
   assign row_addr_byte = 8'({1'b0, cursor_ff} + (CUW+1)'(offset_ff));
   assign req_in_range  = (req.x_pos < mlcd_pkg::POS_W'(PANEL_WIDTH)) &&
                          (req.y_pos < mlcd_pkg::POS_W'(PANEL_HEIGHT));

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_kind_ff;
   assign rsp.pixel_value = rsp_pix_ff;
   assign rsp.serial_byte = rsp_byte_ff;
   assign rsp.frame_last  = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlcd_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (req.mode == mlcd_pkg::MODE_CLEAR)
                  state_in = mlcd_pkg::ST_CLR_CMD;
               else if (req.mode == mlcd_pkg::MODE_REFRESH)
                  state_in = busy_ff ? mlcd_pkg::ST_REF_SCAN : mlcd_pkg::ST_REF_CMD;
               else
                  state_in = mlcd_pkg::ST_PIX_RD;
            end
         end
         mlcd_pkg::ST_PIX_RD:  state_in = mlcd_pkg::ST_PIX_MOD;
         mlcd_pkg::ST_PIX_MOD: begin
            if (mode_ff == mlcd_pkg::MODE_WRITE || can_load)
               state_in = mlcd_pkg::ST_IDLE;
         end
         mlcd_pkg::ST_CLR_CMD: if (can_load) state_in = mlcd_pkg::ST_CLR_END;
         mlcd_pkg::ST_CLR_END: if (can_load) state_in = mlcd_pkg::ST_CLR_FILL;
         mlcd_pkg::ST_CLR_FILL: begin
            if (addr_ff == AW'(STORE_BYTES - 1))
               state_in = mlcd_pkg::ST_IDLE;
         end
         mlcd_pkg::ST_REF_CMD: if (can_load) state_in = mlcd_pkg::ST_REF_SCAN;
         mlcd_pkg::ST_REF_SCAN: begin
            priority if (scan_end)
               state_in = mlcd_pkg::ST_REF_END;
            else if (dirty_ff[cursor_ff[RW-1:0]])
               state_in = mlcd_pkg::ST_REF_ADDR;
         end
         mlcd_pkg::ST_REF_ADDR: if (can_load) state_in = mlcd_pkg::ST_REF_RD;
         mlcd_pkg::ST_REF_RD:   state_in = mlcd_pkg::ST_REF_DATA;
         mlcd_pkg::ST_REF_DATA: begin
            if (can_load)
               state_in = row_last_byte ? mlcd_pkg::ST_REF_TRAIL : mlcd_pkg::ST_REF_RD;
         end
         mlcd_pkg::ST_REF_TRAIL: if (can_load) state_in = mlcd_pkg::ST_IDLE;
         mlcd_pkg::ST_REF_END:   if (can_load) state_in = mlcd_pkg::ST_IDLE;
         default: state_in = mlcd_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      out_load  = 1'b0;
      out_kind  = mlcd_pkg::KIND_SERIAL;
      out_pix   = 1'b0;
      out_byte  = mlcd_pkg::ZERO_BYTE;
      out_last  = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = mlcd_pkg::FILL_BYTE;
      dirty_in  = dirty_ff;
      vcom_in   = vcom_ff;
      busy_in   = busy_ff;
      cursor_in = cursor_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         mlcd_pkg::ST_IDLE: begin
            if (req_fire)
               addr_in = AW'(req.y_pos * ROW_BYTES + req.x_pos[mlcd_pkg::POS_W-1:3]);
         end
         mlcd_pkg::ST_PIX_RD: begin
            mem_re = in_range_ff;
         end
         mlcd_pkg::ST_PIX_MOD: begin
            if (mode_ff == mlcd_pkg::MODE_WRITE) begin
               if (in_range_ff) begin
                  mem_we            = 1'b1;
                  mem_wdata         = pix_on_ff ? (store_rdata_ff | mask_ff)
                                                : (store_rdata_ff & ~mask_ff);
                  dirty_in[yrow_ff] = 1'b1;
               end
            end else if (can_load) begin
               out_load = 1'b1;
               out_kind = mlcd_pkg::KIND_PIXEL;
               out_pix  = in_range_ff && |(store_rdata_ff & mask_ff);
            end
         end
         mlcd_pkg::ST_CLR_CMD: begin
            if (can_load) begin
               out_load  = 1'b1;
               out_byte  = mlcd_pkg::CMD_CLEAR | vcom_bit;
               dirty_in  = '0;
               busy_in   = 1'b0;
               cursor_in = '0;
            end
         end
         mlcd_pkg::ST_CLR_END: begin
            if (can_load) begin
               out_load = 1'b1;
               out_last = 1'b1;
               vcom_in  = !vcom_ff;
               addr_in  = '0;
            end
         end
         mlcd_pkg::ST_CLR_FILL: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + AW'(1);
         end
         mlcd_pkg::ST_REF_CMD: begin
            if (can_load) begin
               out_load  = 1'b1;
               out_byte  = mlcd_pkg::CMD_WRITE | vcom_bit;
               vcom_in   = !vcom_ff;
               busy_in   = 1'b1;
               cursor_in = '0;
            end
         end
         mlcd_pkg::ST_REF_SCAN: begin
            // one row examined per cycle
            if (!scan_end && !dirty_ff[cursor_ff[RW-1:0]])
               cursor_in = cursor_ff + CUW'(1);
         end
         mlcd_pkg::ST_REF_ADDR: begin
            if (can_load) begin
               out_load = 1'b1;
               out_byte = row_addr_byte;
               addr_in  = AW'(cursor_ff * ROW_BYTES);
               cnt_in   = '0;
            end
         end
         mlcd_pkg::ST_REF_RD: begin
            mem_re = 1'b1;
         end
         mlcd_pkg::ST_REF_DATA: begin
            if (can_load) begin
               out_load = 1'b1;
               out_byte = store_rdata_ff;
               addr_in  = addr_ff + AW'(1);
               cnt_in   = cnt_ff + CW'(1);
            end
         end
         mlcd_pkg::ST_REF_TRAIL: begin
            if (can_load) begin
               out_load  = 1'b1;
               cursor_in = cursor_ff + CUW'(1);
            end
         end
         mlcd_pkg::ST_REF_END: begin
            if (can_load) begin
               out_load  = 1'b1;
               out_last  = 1'b1;
               dirty_in  = '0;
               busy_in   = 1'b0;
               cursor_in = '0;
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // frame store, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we)
         frame_store_mem[mem_addr] <= mem_wdata;
      if (mem_re)
         store_rdata_ff <= frame_store_mem[mem_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlcd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dirty_ff     <= '0;
         vcom_ff      <= 1'b1;
         busy_ff      <= 1'b0;
         cursor_ff    <= '0;
         offset_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         dirty_ff  <= dirty_in;
         vcom_ff   <= vcom_in;
         busy_ff   <= busy_in;
         cursor_ff <= cursor_in;
         if (out_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
         if (csr_wr_en)
            offset_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_pix_ff  <= out_pix;
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= out_last;
      end
      if (req_fire) begin
         mode_ff     <= mlcd_pkg::mode_type'(req.mode);
         pix_on_ff   <= req.pixel_on;
         in_range_ff <= req_in_range;
         mask_ff     <= mlcd_pkg::PIX_MSB >> req.x_pos[2:0];
         yrow_ff     <= RW'(req.y_pos);
      end
   end

endmodule

[hdl/mlcd_checker.sv]
// ----------------------------------------------------------------------------
// mlcd_checker
// Port-level checks for the memory-LCD frame controller, bound to the top.
// ----------------------------------------------------------------------------
module mlcd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_kind,
   input logic                         rsp_pixel_value,
   input logic [mlcd_pkg::BYTE_W-1:0]  rsp_serial_byte,
   input logic                         rsp_frame_last
);

   // one command at a time: a transfer always leaves the idle state
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_serial_byte) &&
         $stable(rsp_kind) && $stable(rsp_frame_last) && $stable(rsp_pixel_value))
      else $error("stalled response changed");

   a_pixel_answer_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == mlcd_pkg::KIND_PIXEL) |->
         (rsp_serial_byte == mlcd_pkg::ZERO_BYTE) && !rsp_frame_last)
      else $error("pixel answer carries serial fields");

   a_serial_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == mlcd_pkg::KIND_SERIAL) |-> !rsp_pixel_value)
      else $error("serial byte carries a pixel value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind memory_lcd_frame_controller_unit mlcd_checker u_mlcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_kind        (rsp.kind),
   .rsp_pixel_value (rsp.pixel_value),
   .rsp_serial_byte (rsp.serial_byte),
   .rsp_frame_last  (rsp.frame_last)
);
